### hdl/ihex_pkg.sv
`timescale 1ns / 1ps
// Package for the Intel HEX word record parser: field widths, phase codes,
// character codes, the result record type and the hex digit decoder. No dependencies.
package ihex_pkg;

  localparam int DATA_BITS = 14;

  localparam int CHAR_W = 8;
  localparam int ADDR_W = 16;
  localparam int WDATA_W = 14;
  localparam int WCNT_W = 7;
  localparam int PHASE_W = 3;

  // Mask applied to the assembled 16-bit word before it is cut to the field.
  localparam logic [15:0] DATA_MASK =
    (DATA_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << DATA_BITS) - 32'd1);

  localparam logic [PHASE_W-1:0] PH_START = 3'd0;
  localparam logic [PHASE_W-1:0] PH_COUNT = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ADDR  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TYPE  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CHECK = 3'd5;

  localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

  localparam logic EV_DATA = 1'b0;
  localparam logic EV_STOP = 1'b1;

  typedef struct packed {
    logic               event_kind;
    logic [ADDR_W-1:0]  word_address;
    logic [WDATA_W-1:0] word_data;
  } result_t;

  // Value of one hex digit; any other character reads as zero.
  function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

endpackage

### hdl/intel_hex_word_record_parser_top.sv
`timescale 1ns / 1ps
// Intel HEX word record parser, top level. A completed result is registered in the
// output register, or in the skid entry while that is held. One character is taken
// per cycle while in_stall is low. The parse state updates at the accepting edge; a
// two-entry output register and skid stage keep input acceptance running while a
// result waits downstream. Reset (synchronous, rst_n low) returns the parser to
// record start, clears the stop flag and empties both output entries.
module intel_hex_word_record_parser_top
  import ihex_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CHAR_W-1:0]  in_char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_event_kind,
  output logic [ADDR_W-1:0]  out_word_address,
  output logic [WDATA_W-1:0] out_word_data
);

  // Parser state. The first nibble of a byte is held on its own, since the
  // second nibble completes the byte in the same cycle it arrives.
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               nib_second_r, nib_second_nxt;
  logic [3:0]         nib_hold_r, nib_hold_nxt;
  logic               byte_idx_r, byte_idx_nxt;
  logic [WCNT_W-1:0]  words_left_r, words_left_nxt;
  logic [ADDR_W-1:0]  cur_addr_r, cur_addr_nxt;
  logic [7:0]         low_byte_r, low_byte_nxt;
  logic               stopped_r, stopped_nxt;

  // Output register and skid entry.
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_res_r, skid_res_nxt;

  logic       accept;
  logic       res_valid;
  result_t    res;
  logic [3:0] digit;
  logic [7:0] byte_val;
  logic [15:0] word_val;

  // The input side stalls only when the skid entry is occupied.
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;

  assign digit    = hex_value(in_char_code);
  assign byte_val = {nib_hold_r, digit};
  assign word_val = {byte_val, low_byte_r} & DATA_MASK;

  // One character of parsing. Result and state update are both decided here.
  always_comb begin
    phase_nxt      = phase_r;
    nib_second_nxt = nib_second_r;
    nib_hold_nxt   = nib_hold_r;
    byte_idx_nxt   = byte_idx_r;
    words_left_nxt = words_left_r;
    cur_addr_nxt   = cur_addr_r;
    low_byte_nxt   = low_byte_r;
    stopped_nxt    = stopped_r;
    res_valid      = 1'b0;
    res.event_kind   = EV_DATA;
    res.word_address = cur_addr_r;
    res.word_data    = word_val[WDATA_W-1:0];

    if (accept && !stopped_r) begin
      if (phase_r < PH_COUNT || phase_r > PH_CHECK) begin
        // Between records: newline is skipped, a colon opens a record and
        // anything else ends parsing for good.
        phase_nxt = PH_START;
        if (in_char_code == CHAR_COLON) begin
          phase_nxt      = PH_COUNT;
          nib_second_nxt = 1'b0;
          byte_idx_nxt   = 1'b0;
        end else if (in_char_code != CHAR_NEWLINE) begin
          stopped_nxt      = 1'b1;
          res_valid        = 1'b1;
          res.event_kind   = EV_STOP;
          res.word_address = '0;
          res.word_data    = '0;
        end
      end else if (!nib_second_r) begin
        nib_hold_nxt   = digit;
        nib_second_nxt = 1'b1;
      end else begin
        nib_second_nxt = 1'b0;
        nib_hold_nxt   = byte_val[3:0];
        case (phase_r)
          PH_COUNT: begin
            words_left_nxt = byte_val[7:1];
            byte_idx_nxt   = 1'b0;
            phase_nxt      = PH_ADDR;
          end
          PH_ADDR: begin
            if (!byte_idx_r) begin
              cur_addr_nxt = {byte_val, 8'h00};
              byte_idx_nxt = 1'b1;
            end else begin
              // Byte address halved gives the word address.
              cur_addr_nxt = {1'b0, cur_addr_r[15:8], byte_val[7:1]};
              byte_idx_nxt = 1'b0;
              phase_nxt    = PH_TYPE;
            end
          end
          PH_TYPE: begin
            byte_idx_nxt = 1'b0;
            phase_nxt    = (words_left_r != '0) ? PH_DATA : PH_CHECK;
          end
          PH_DATA: begin
            if (!byte_idx_r) begin
              low_byte_nxt = byte_val;
              byte_idx_nxt = 1'b1;
            end else begin
              res_valid      = 1'b1;
              cur_addr_nxt   = cur_addr_r + 16'd1;
              words_left_nxt = words_left_r - 7'd1;
              byte_idx_nxt   = 1'b0;
              if (words_left_r == 7'd1) begin
                phase_nxt = PH_CHECK;
              end
            end
          end
          default: begin
            // Checksum byte is read and dropped.
            phase_nxt = PH_START;
          end
        endcase
      end
    end
  end

  // Output register with skid entry. A new result goes to the output register
  // when it is free or draining this cycle, otherwise into the skid entry.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        if (res_valid) begin
          out_res_nxt = res;
        end
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      nib_second_r <= 1'b0;
      nib_hold_r   <= '0;
      byte_idx_r   <= 1'b0;
      words_left_r <= '0;
      cur_addr_r   <= '0;
      low_byte_r   <= '0;
      stopped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      nib_second_r <= nib_second_nxt;
      nib_hold_r   <= nib_hold_nxt;
      byte_idx_r   <= byte_idx_nxt;
      words_left_r <= words_left_nxt;
      cur_addr_r   <= cur_addr_nxt;
      low_byte_r   <= low_byte_nxt;
      stopped_r    <= stopped_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_res_r.event_kind;
  assign out_word_address = out_res_r.word_address;
  assign out_word_data    = out_res_r.word_data;

  // The skid entry is only ever filled behind a held output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // Once stopped, the parser produces no further results.
  a_no_result_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> !res_valid)
    else $error("result produced after parsing stopped");

  // A data word advances the word address by one.
  a_addr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.event_kind == EV_DATA) |=> cur_addr_r == $past(cur_addr_r) + 16'd1)
    else $error("word address did not advance after a data word");

  // The stop flag only rises on an accepted character.
  a_stop_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stopped_r) |-> $past(accept))
    else $error("stop flag set without an accepted character");

endmodule

### verif/tb_intel_hex_word_record_parser_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Intel HEX word record parser top level.
// Depends on ihex_pkg for widths, phase codes, character codes and result_t.
module tb_intel_hex_word_record_parser_top;
  import ihex_pkg::*;

  // The random part stops once about this many characters have been accepted.
  localparam int CHAR_TARGET = 1850;
  // Length of the one long receiver hold-off that fills up the block.
  localparam int HOLD_CYCLES = 400;
  // Cycles without any transaction on either side before the run is declared hung.
  // The longest legal quiet stretch is the hold-off above, so this is ample.
  localparam int IDLE_LIMIT = 4000;
  // Mismatches past this many are only counted.
  localparam int REPORT_LIMIT = 10;
  // Mask of the configured data width applied to each assembled word.
  localparam logic [15:0] WORD_MASK =
    (DATA_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << DATA_BITS) - 32'd1);

  // The scoreboard carries its own copy of the parser state. Each accepted
  // character advances that copy, and any word or stop event it produces is
  // queued for comparison with the next result transaction.
  class hex_word_scoreboard;
    logic [PHASE_W-1:0] phase = PH_START;
    logic               second_nibble = 1'b0;
    logic [7:0]         acc = 8'h00;
    logic               byte_pos = 1'b0;
    logic [WCNT_W-1:0]  words_left = '0;
    logic [ADDR_W-1:0]  cur_addr = '0;
    logic [7:0]         low_byte = 8'h00;
    logic               halted = 1'b0;
    result_t            pending_words[$];
    int                 failures = 0;

    function logic [3:0] digit_of(logic [CHAR_W-1:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      return 4'd0;
    endfunction

    function void note_char(logic [CHAR_W-1:0] c);
      logic [7:0] b;
      result_t    ev;
      if (halted) return;
      if (phase < PH_COUNT || phase > PH_CHECK) begin
        phase = PH_START;
        if (c == CHAR_NEWLINE) return;
        if (c == CHAR_COLON) begin
          phase = PH_COUNT;
          second_nibble = 1'b0;
          byte_pos = 1'b0;
          return;
        end
        halted = 1'b1;
        ev.event_kind = EV_STOP;
        ev.word_address = '0;
        ev.word_data = '0;
        pending_words.push_back(ev);
        return;
      end
      if (!second_nibble) begin
        acc = {4'h0, digit_of(c)};
        second_nibble = 1'b1;
        return;
      end
      b = {acc[3:0], digit_of(c)};
      acc = b;
      second_nibble = 1'b0;
      case (phase)
        PH_COUNT: begin
          words_left = b[7:1];
          byte_pos = 1'b0;
          phase = PH_ADDR;
        end
        PH_ADDR: begin
          if (!byte_pos) begin
            cur_addr = {b, 8'h00};
            byte_pos = 1'b1;
          end else begin
            // Byte address halved to a word address.
            cur_addr = {1'b0, cur_addr[15:8], b[7:1]};
            byte_pos = 1'b0;
            phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          byte_pos = 1'b0;
          phase = (words_left != 0) ? PH_DATA : PH_CHECK;
        end
        PH_DATA: begin
          if (!byte_pos) begin
            low_byte = b;
            byte_pos = 1'b1;
          end else begin
            ev.event_kind = EV_DATA;
            ev.word_address = cur_addr;
            ev.word_data = WDATA_W'({b, low_byte} & WORD_MASK);
            pending_words.push_back(ev);
            cur_addr = cur_addr + 1'b1;
            words_left = words_left - 1'b1;
            byte_pos = 1'b0;
            if (words_left == 0) phase = PH_CHECK;
          end
        end
        default: phase = PH_START;
      endcase
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_words.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("ERROR: unexpected result kind=%0d addr=%h data=%h",
                   got.event_kind, got.word_address, got.word_data);
        return;
      end
      want = pending_words.pop_front();
      if (got.event_kind !== want.event_kind || got.word_address !== want.word_address ||
          got.word_data !== want.word_data) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("ERROR: expected kind=%0d addr=%h data=%h, got kind=%0d addr=%h data=%h",
                   want.event_kind, want.word_address, want.word_data,
                   got.event_kind, got.word_address, got.word_data);
      end
    endfunction

    function int expected_left();
      return pending_words.size();
    endfunction

    function void flag_leftovers();
      if (pending_words.size() != 0) begin
        failures++;
        $display("ERROR: %0d expected results never arrived", pending_words.size());
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CHAR_W-1:0]  in_char_code = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_event_kind;
  logic [ADDR_W-1:0]  out_word_address;
  logic [WDATA_W-1:0] out_word_data;

  hex_word_scoreboard sb = new;

  // Traffic shaping shared between the sender and receiver processes.
  int sender_mode = 0;
  int chars_sent = 0;
  bit hold_req = 1'b0;
  bit hold_busy = 1'b0;

  intel_hex_word_record_parser_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_word_address (out_word_address),
    .out_word_data    (out_word_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap after a character. Mode 0 streams back to back, mode 1 adds short
  // gaps, mode 2 adds short gaps and the occasional long one. During the
  // long receiver hold-off the sender keeps offering without gaps.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_mode == 0 || hold_busy) return 0;
    if (r < 60) return 0;
    if (r < 95 || sender_mode == 1) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one character and holds it until the block takes it. Valid stays
  // high into the next character when no gap follows.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    in_valid <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (in_stall);
    sb.note_char(c);
    chars_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Hex digit for a nibble, with letters in either case.
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  // Two digits of a byte, high first. A noisy byte may have any digit
  // replaced by an arbitrary character, which the parser reads as some value.
  task automatic send_byte(input logic [7:0] b, input bit noisy);
    logic [CHAR_W-1:0] c;
    c = hex_char(b[7:4]);
    if (noisy && $urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
    send_char(c);
    c = hex_char(b[3:0]);
    if (noisy && $urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
    send_char(c);
  endtask

  function automatic logic [7:0] pick_data_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly short records keep the run dense in results; a few reach the
  // largest byte count.
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 12);
    if (r < 95) return $urandom_range(13, 40);
    if (r < 98) return $urandom_range(41, 254);
    return 255;
  endfunction

  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hFFFE;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One record: colon, count, address, type, whole words, checksum, then up
  // to two newlines. An odd count keeps only its whole words, since the
  // parser takes the checksum right after them. The count byte is always
  // sent clean, so the record length the parser sees matches the text. A
  // broken record is cut short and then padded with arbitrary characters
  // until the parser is back at record start, so the run does not stop early.
  task automatic send_record(input int count, input logic [15:0] addr,
                             input bit noisy, input bit broken);
    logic [7:0] rec_bytes[$];
    logic [7:0] sum;
    int         keep;
    rec_bytes = {};
    rec_bytes.push_back(8'(count));
    rec_bytes.push_back(addr[15:8]);
    rec_bytes.push_back(addr[7:0]);
    rec_bytes.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 5)));
    for (int i = 0; i < (count / 2) * 2; i++) rec_bytes.push_back(pick_data_byte());
    sum = 8'h00;
    foreach (rec_bytes[i]) sum = sum + rec_bytes[i];
    rec_bytes.push_back(8'h00 - sum);
    keep = broken ? $urandom_range(0, rec_bytes.size() - 1) : rec_bytes.size();
    send_char(CHAR_COLON);
    for (int i = 0; i < keep; i++) send_byte(rec_bytes[i], noisy && (i != 0));
    if (broken) begin
      if ($urandom_range(0, 1)) send_char(8'($urandom_range(0, 255)));
      while (sb.phase != PH_START) send_char(8'($urandom_range(0, 255)));
    end
    repeat ($urandom_range(0, 2)) send_char(CHAR_NEWLINE);
  endtask

  // Lowers valid and waits until every queued result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_left() != 0) @(posedge clk);
  endtask

  // Receiver. It samples the result channel at each edge, then picks the
  // stall for the next cycle. A hold-off request from the sender makes it
  // stall without a break through the long hold-off, long enough to fill the
  // output stage and push back on the input.
  initial begin
    int stall_left;
    int hold_left;
    int recv_mode;
    int mode_cycles;
    int r;
    result_t got;
    stall_left = 0;
    hold_left = 0;
    recv_mode = 0;
    mode_cycles = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.event_kind = out_event_kind;
        got.word_address = out_word_address;
        got.word_data = out_word_data;
        sb.check_word(got);
      end
      mode_cycles++;
      if (mode_cycles >= 64) begin
        mode_cycles = 0;
        recv_mode = $urandom_range(0, 2);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_busy = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_busy) begin
        hold_left--;
        if (hold_left == 0) begin
          hold_busy = 1'b0;
          out_stall <= 1'b0;
        end
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        case (recv_mode)
          0: out_stall <= 1'b0;
          1: begin
            if (r < 25) begin
              stall_left = $urandom_range(0, 2);
              out_stall <= 1'b1;
            end else begin
              out_stall <= 1'b0;
            end
          end
          default: begin
            if (r < 5) begin
              stall_left = $urandom_range(10, 40);
              out_stall <= 1'b1;
            end else begin
              out_stall <= (r < 30);
            end
          end
        endcase
      end
    end
  end

  // Watchdog: any cycle with a transaction on either side restarts the count.
  always @(posedge clk) begin : watchdog
    int idle;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle = 0;
      end else begin
        idle++;
        if (idle >= IDLE_LIMIT) begin
          $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
          $display("Some tests failed");
          $finish;
        end
      end
    end else begin
      idle = 0;
    end
  end

  // Stimulus. The directed text covers a zero byte count at the top address,
  // a non-hex digit in a checksum, newlines between records, an odd byte
  // count, lowercase digits and a data word that overflows the data width.
  // The random records follow, with noisy and cut-short records mixed in.
  // The stop event ends parsing for good, so it comes last, followed by a
  // few characters that must be ignored.
  initial begin
    int rec_no;
    logic [CHAR_W-1:0] stop_char;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text(":00FFFF00Z0\n:03FFFE00ffFF00\n");

    rec_no = 0;
    while (chars_sent < CHAR_TARGET) begin
      sender_mode = $urandom_range(0, 2);
      if (rec_no == 4) begin
        // A long record while the receiver holds off fills the block.
        hold_req = 1'b1;
        send_record(40, pick_address(), 1'b0, 1'b0);
      end else if (rec_no == 12) begin
        drain_results();
        send_record(pick_count(), pick_address(), 1'b0, 1'b0);
      end else begin
        send_record(pick_count(), pick_address(),
                    ($urandom_range(0, 99) < 15), ($urandom_range(0, 99) < 8));
      end
      rec_no++;
    end

    do stop_char = 8'($urandom_range(0, 255));
    while (stop_char == CHAR_COLON || stop_char == CHAR_NEWLINE);
    send_char(stop_char);
    send_char(CHAR_COLON);
    repeat (10) send_char(8'($urandom_range(0, 255)));

    drain_results();
    repeat (20) @(posedge clk);
    sb.flag_leftovers();
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/ihex_pkg.sv
hdl/intel_hex_word_record_parser_top.sv
verif/tb_intel_hex_word_record_parser_top.sv
